/* hw/rtl/vlan_range_bitmap_top_assert.svh */
// Assertion macros used by the top-level RTL of the VLAN range bitmap.
`ifndef VLAN_RANGE_BITMAP_TOP_ASSERT_SVH
`define VLAN_RANGE_BITMAP_TOP_ASSERT_SVH

// Same-cycle implication.
`define VRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrb: same-cycle check failed");

// Next-cycle implication.
`define VRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vrb: next-cycle check failed");

`endif

/* hw/rtl/vrb_pkg.sv */
`timescale 1ns / 1ps

package vrb_pkg;

   localparam int ID_COUNT_DEF  = 4096;
   localparam int WORD_BITS_DEF = 64;
   localparam int ID_W          = 12;
   // wide enough for a bit position 0..64 inclusive
   localparam int POS_W         = 7;

   typedef enum logic [1:0] {
      KIND_ALLOW    = 2'd0,
      KIND_DISALLOW = 2'd1,
      KIND_FIND     = 2'd2,
      KIND_NOP      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             nz;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
   } scan_res_type;

endpackage

/* hw/rtl/vrb_ram.sv */
`timescale 1ns / 1ps

module vrb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/vrb_scan.sv */
`timescale 1ns / 1ps

// Per-word unit: range mask for updates, and first-run location for searches.
module vrb_scan #(
   parameter int WORD_BITS = 64,
   parameter int CW        = 14
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic [CW-1:0]        base,
   input  logic [CW-1:0]        lo,
   input  logic [CW-1:0]        hi,
   input  logic                 cont,
   output logic [WORD_BITS-1:0] upd_mask,
   output vrb_pkg::scan_res_type res
);

   localparam int SW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   logic [CW-1:0]        lo_diff;
   logic [CW-1:0]        hi_diff;
   logic [WORD_BITS-1:0] ge_mask;
   logic [WORD_BITS-1:0] le_mask;
   logic [WORD_BITS-1:0] x;
   logic [WORD_BITS-1:0] lsb;
   logic [WORD_BITS:0]   sum;

   function automatic logic [vrb_pkg::POS_W-1:0] low_set(input logic [WORD_BITS:0] v);
      logic [vrb_pkg::POS_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS; i >= 0; i--) begin
         if (v[i]) begin
            r = vrb_pkg::POS_W'(i);
         end
      end
      return r;
   endfunction

   assign lo_diff = lo - base;
   assign hi_diff = hi - base;

   always_comb begin
      priority if (lo <= base) begin
         ge_mask = '1;
      end else if (lo_diff >= CW'(WORD_BITS)) begin
         ge_mask = '0;
      end else begin
         ge_mask = {WORD_BITS{1'b1}} << lo_diff[SW-1:0];
      end
   end

   always_comb begin
      priority if (hi < base) begin
         le_mask = '0;
      end else if (hi_diff >= CW'(WORD_BITS - 1)) begin
         le_mask = '1;
      end else begin
         le_mask = {WORD_BITS{1'b1}} >> (SW'(WORD_BITS - 1) - hi_diff[SW-1:0]);
      end
   end

   assign upd_mask = ge_mask & le_mask;

   // Adding the lowest set bit to x clears its lowest run of ones and sets
   // the bit just past it; in continue mode the run is forced to start at bit 0.
   assign x   = cont ? word : (word & ge_mask);
   assign lsb = cont ? WORD_BITS'(1) : (x & (~x + WORD_BITS'(1)));
   assign sum = {1'b0, x} + {1'b0, lsb};

   assign res.nz        = |x;
   assign res.start_pos = low_set({1'b0, x});
   assign res.end_pos   = low_set(sum);

endmodule

/* hw/rtl/vlan_range_bitmap_top.sv */
// VLAN allow bitmap with inclusive range set/clear and next-run search. One
// bit per VLAN ID is held in a RAM of WORD_BITS-wide words. Each request
// (req_tuser = kind) either sets (allow) or clears (disallow) the IDs
// low_id..high_id, or searches for the first allowed ID at or after low_id
// and reports the run it opens; every request gets exactly one response,
// found=0 with zero IDs for updates, no-ops and failed searches. A request
// walks the bitmap one word per cycle through a single shared word unit,
// read-modify-write pipelined against the RAM's registered read; an update
// walks every word (64 at the default 4096 IDs in 64-bit words), a search
// stops early when its run ends, and a no-op skips the walk. req_tready is
// low while a request is being walked. After reset a clearing pass zeroes
// the bitmap word by word before the first request is taken. A finished
// response waits in the output register while the next request is accepted.
`timescale 1ns / 1ps
`include "vlan_range_bitmap_top_assert.svh"

module vlan_range_bitmap_top #(
   parameter int ID_COUNT  = vrb_pkg::ID_COUNT_DEF,
   parameter int WORD_BITS = vrb_pkg::WORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*vrb_pkg::ID_W-1:0] req_tdata,   // [11:0] low_id, [23:12] high_id
   input  logic [1:0]                req_tuser,   // [1:0] kind
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [2*vrb_pkg::ID_W-1:0] rsp_tdata,   // [11:0] run_start, [23:12] run_end
   output logic [0:0]                rsp_tuser    // [0] found
);

   localparam int ID_W       = vrb_pkg::ID_W;
   localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int TOTAL      = WORD_COUNT * WORD_BITS;
   localparam int CW         = (($clog2(TOTAL) > ID_W) ? $clog2(TOTAL) : ID_W) + 1;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int NW         = $clog2(WORD_COUNT + 1);

   // sequencer state
   vrb_pkg::state_type state_ff, state_in;

   // walk counters: read side and data side of the RAM pipeline
   logic [NW-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CW-1:0] rd_base_ff, rd_base_in;
   logic          d_vld_ff, d_vld_in;
   logic [AW-1:0] d_idx_ff, d_idx_in;
   logic [CW-1:0] d_base_ff, d_base_in;

   // request held for the walk
   vrb_pkg::kind_type kind_ff, kind_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic              rng_ok_ff, rng_ok_in;

   // search progress
   logic          found_ff, found_in;
   logic          cont_ff, cont_in;
   logic [CW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] run_end_ff, run_end_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_found_ff, rsp_found_in;
   logic [ID_W-1:0] rsp_start_ff, rsp_start_in;
   logic [ID_W-1:0] rsp_end_ff, rsp_end_in;

   // control and datapath nets
   logic                 req_acc;
   logic                 rd_issue;
   logic                 rsp_load;
   logic                 walk_word;
   logic                 last_word;
   logic                 search_stop;
   logic                 walk_end;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;
   logic [WORD_BITS-1:0] upd_mask;
   logic [WORD_BITS-1:0] upd_word;
   logic [CW-1:0]        hi_x;
   logic [CW-1:0]        lo_x;
   logic [CW-1:0]        hi_clamp;
   vrb_pkg::scan_res_type scan_res;

   vrb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   vrb_scan #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW)
   ) u_scan (
      .word     (ram_rdata),
      .base     (d_base_ff),
      .lo       (lo_ff),
      .hi       (hi_ff),
      .cont     (cont_ff),
      .upd_mask (upd_mask),
      .res      (scan_res)
   );

   assign req_acc = req_tvalid && req_tready;

   // Clamp the range end to the last ID; an empty range leaves the bitmap alone.
   assign lo_x     = CW'(req_tdata[ID_W-1:0]);
   assign hi_x     = CW'(req_tdata[2*ID_W-1:ID_W]);
   assign hi_clamp = (hi_x > CW'(ID_COUNT - 1)) ? CW'(ID_COUNT - 1) : hi_x;

   assign walk_word = (state_ff == vrb_pkg::ST_WALK) && d_vld_ff;
   assign last_word = (d_idx_ff == AW'(WORD_COUNT - 1));

   always_comb begin
      unique case (kind_ff)
         vrb_pkg::KIND_ALLOW:    upd_word = rng_ok_ff ? (ram_rdata | upd_mask) : ram_rdata;
         vrb_pkg::KIND_DISALLOW: upd_word = rng_ok_ff ? (ram_rdata & ~upd_mask) : ram_rdata;
         default:                upd_word = ram_rdata;
      endcase
   end

   // Search: find the run start, then follow the run across words until a
   // zero bit or the end of the bitmap.
   always_comb begin
      found_in     = found_ff;
      cont_in      = cont_ff;
      run_start_in = run_start_ff;
      run_end_in   = run_end_ff;
      search_stop  = 1'b0;
      if (walk_word && (kind_ff == vrb_pkg::KIND_FIND)) begin
         if (cont_ff) begin
            if (scan_res.end_pos != vrb_pkg::POS_W'(WORD_BITS)) begin
               run_end_in  = d_base_ff + CW'(scan_res.end_pos) - CW'(1);
               cont_in     = 1'b0;
               search_stop = 1'b1;
            end
         end else if (scan_res.nz) begin
            found_in     = 1'b1;
            run_start_in = d_base_ff + CW'(scan_res.start_pos);
            if (scan_res.end_pos == vrb_pkg::POS_W'(WORD_BITS)) begin
               cont_in = 1'b1;
            end else begin
               run_end_in  = d_base_ff + CW'(scan_res.end_pos) - CW'(1);
               search_stop = 1'b1;
            end
         end
         // run still open at the top of the bitmap: close it there
         if (last_word && cont_in && !search_stop) begin
            run_end_in = d_base_ff + CW'(WORD_BITS - 1);
            cont_in    = 1'b0;
         end
      end
      if (req_acc) begin
         found_in     = 1'b0;
         cont_in      = 1'b0;
         run_start_in = '0;
         run_end_in   = '0;
      end
   end

   assign walk_end = walk_word && (last_word || search_stop);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vrb_pkg::ST_CLEAR: begin
            if (rd_cnt_ff == NW'(WORD_COUNT - 1)) begin
               state_in = vrb_pkg::ST_IDLE;
            end
         end
         vrb_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = (vrb_pkg::kind_type'(req_tuser) == vrb_pkg::KIND_NOP) ?
                          vrb_pkg::ST_DONE : vrb_pkg::ST_WALK;
            end
         end
         vrb_pkg::ST_WALK: begin
            if (walk_end) begin
               state_in = vrb_pkg::ST_DONE;
            end
         end
         vrb_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = vrb_pkg::ST_IDLE;
            end
         end
         default: state_in = vrb_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rd_issue   = 1'b0;
      rsp_load   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = d_idx_ff;
      ram_wdata  = upd_word;
      ram_raddr  = rd_cnt_ff[AW-1:0];
      unique case (state_ff)
         vrb_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = rd_cnt_ff[AW-1:0];
            ram_wdata = '0;
         end
         vrb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         vrb_pkg::ST_WALK: begin
            rd_issue = (rd_cnt_ff < NW'(WORD_COUNT)) && !walk_end;
            ram_we   = d_vld_ff && ((kind_ff == vrb_pkg::KIND_ALLOW) ||
                                    (kind_ff == vrb_pkg::KIND_DISALLOW));
         end
         vrb_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // walk counters and held request
   always_comb begin
      rd_cnt_in  = rd_cnt_ff;
      rd_base_in = rd_base_ff;
      d_vld_in   = rd_issue;
      d_idx_in   = rd_issue ? rd_cnt_ff[AW-1:0] : d_idx_ff;
      d_base_in  = rd_issue ? rd_base_ff : d_base_ff;
      kind_in    = kind_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      rng_ok_in  = rng_ok_ff;
      priority if (state_ff == vrb_pkg::ST_CLEAR) begin
         rd_cnt_in = rd_cnt_ff + NW'(1);
         if (rd_cnt_ff == NW'(WORD_COUNT - 1)) begin
            rd_cnt_in = '0;
         end
      end else if (req_acc) begin
         rd_cnt_in  = '0;
         rd_base_in = '0;
         d_vld_in   = 1'b0;
         kind_in    = vrb_pkg::kind_type'(req_tuser);
         lo_in      = lo_x;
         hi_in      = hi_clamp;
         rng_ok_in  = (lo_x <= hi_clamp);
      end else if (rd_issue) begin
         rd_cnt_in  = rd_cnt_ff + NW'(1);
         rd_base_in = rd_base_ff + CW'(WORD_BITS);
      end else begin
         // hold the counters while idle, answering, or when no read is issued
         rd_cnt_in = rd_cnt_ff;
      end
   end

   // response register: load from DONE, drop when taken
   always_comb begin
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_start_in = found_ff ? run_start_ff[ID_W-1:0] : '0;
         rsp_end_in   = found_ff ? run_end_ff[ID_W-1:0] : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrb_pkg::ST_CLEAR;
         rd_cnt_ff    <= '0;
         d_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         d_vld_ff     <= d_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_base_ff   <= rd_base_in;
      d_idx_ff     <= d_idx_in;
      d_base_ff    <= d_base_in;
      kind_ff      <= kind_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rng_ok_ff    <= rng_ok_in;
      found_ff     <= found_in;
      cont_ff      <= cont_in;
      run_start_ff <= run_start_in;
      run_end_ff   <= run_end_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_end_ff, rsp_start_ff};
   assign rsp_tuser[0] = rsp_found_ff;

   // an accepted request always starts a walk or goes straight to the answer
   `VRB_ASSERT_NEXT(a_accept_starts, clock, reset, req_acc,
      state_ff == vrb_pkg::ST_WALK || state_ff == vrb_pkg::ST_DONE)
   // the bitmap is written only by the clearing pass or an update walk
   `VRB_ASSERT_NOW(a_write_state, clock, reset, ram_we,
      state_ff == vrb_pkg::ST_CLEAR || state_ff == vrb_pkg::ST_WALK)
   // a response appears only out of the answer state
   `VRB_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == vrb_pkg::ST_DONE))
   // a negative answer carries zero IDs
   `VRB_ASSERT_NOW(a_nofind_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
      rsp_start_ff == '0 && rsp_end_ff == '0)
   // a found run never ends before it starts
   `VRB_ASSERT_NOW(a_run_order, clock, reset, rsp_valid_ff && rsp_found_ff,
      rsp_end_ff >= rsp_start_ff)

endmodule
